[src/ese_pkg.sv]
// ----------------------------------------------------------------------------
// ese_pkg: shared types and constants of the encoder speed estimator
// Function codes, fixed-point constants, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package ese_pkg;

    localparam int TIME_BITS = 32;
    localparam int FRAC_BITS = 8;

    // function codes of an input item
    localparam logic [1:0] FUNC_EDGE  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // register indexes on the configuration port
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_WEIGHT   = 2'd1;
    localparam logic [1:0] REG_PPR      = 2'd2;

    // 1e6 * 60 / 128 in Q format
    localparam logic [63:0] SPEED_K = 64'd468750 << FRAC_BITS;
    // 360 degrees in Q format
    localparam logic [63:0] ANGLE_K = 64'd360 << FRAC_BITS;
    // outlier limit, 0.5 rpm deadband, 1.0 rpm
    localparam logic [22:0] LIMIT   = 23'(64'd10000 << FRAC_BITS);
    localparam logic [22:0] HALF    = 23'(64'd1 << (FRAC_BITS - 1));
    localparam logic [26:0] ONE     = 27'(64'd1 << FRAC_BITS);

    typedef enum logic [1:0] {
        DIV_SPEED,
        DIV_FILT,
        DIV_ANGLE
    } div_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_SGO,
        S_SWAIT,
        S_RPM,
        S_FGO,
        S_FWAIT,
        S_FPOST,
        S_AGO,
        S_AWAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [15:0] debounce_us;
        logic [7:0]  filter_weight;
        logic [15:0] pulses_per_rev;
    } cfg_t;

    typedef struct packed {
        logic     load;
        logic     exec;
        logic     mul;
        logic     div_start;
        div_sel_t div_sel;
        logic     rpm;
        logic     fpost;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic is_read;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

[src/ese_div.sv]
// ----------------------------------------------------------------------------
// ese_div: shared restoring divider
// Unsigned 64 by 32 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ese_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] num,
    input  wire logic [31:0] den,
    output logic      [63:0] quot,
    output logic             done
);
    logic [31:0] rem_reg, rem_next;
    logic [63:0] quot_reg, quot_next;
    logic [31:0] den_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] shifted;
    logic        fits;

    // one restoring step
    always_comb begin
        shifted = {rem_reg, quot_reg[63]};
        fits    = shifted >= {1'b0, den_reg};
        rem_next  = fits ? 32'(shifted - {1'b0, den_reg}) : shifted[31:0];
        quot_next = {quot_reg[62:0], fits};
        cnt_next  = cnt_reg - 7'd1;
        busy_next = cnt_reg != 7'd1;
        done_next = cnt_reg == 7'd1;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd64;
        end else if (busy_reg) begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operands
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            quot_reg <= num;
            den_reg  <= den;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;
    assign done = done_reg;

    a_busy_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !done_reg) else $error("divider done while busy");
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg && !done_reg) else $error("divider did not start");
    a_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && cnt_reg == 7'd1 && !start |=> done_reg)
        else $error("divider did not finish");

endmodule
`default_nettype wire

[src/ese_datapath.sv]
// ----------------------------------------------------------------------------
// ese_datapath: encoder state, speed arithmetic and result register
// Holds the counter and timing state, the filter and peak state and the
// output register; runs the three divisions on one shared divider.
// ----------------------------------------------------------------------------
`default_nettype none
module ese_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire ese_pkg::cfg_t       cfg,
    input  wire ese_pkg::cmd_t       cmd,
    output ese_pkg::sts_t            sts,
    input  wire logic [1:0]          s_func,
    input  wire logic                s_pin_level,
    input  wire logic [31:0]         s_time_us,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [31:0]              m_pulse_count,
    output logic [48:0]              m_angle_q8,
    output logic signed [22:0]       m_rpm_raw,
    output logic signed [22:0]       m_rpm_filtered,
    output logic signed [22:0]       m_rpm_peak
);
    import ese_pkg::*;

    // latched item
    logic [1:0]           func_reg;
    logic                 level_reg;
    logic [TIME_BITS-1:0] now_reg;

    // encoder and speed state
    logic                 last_level_reg;
    logic [TIME_BITS-1:0] last_edge_reg, latest_ev_reg, tolpr_reg;
    logic [31:0]          count_reg, calr_reg;
    logic                 first_reg;
    logic signed [22:0]   good_reg, filt_reg, peak_reg;

    // per-read scratch
    logic [31:0]          cnt_reg;
    logic [TIME_BITS-1:0] dt_reg;
    logic                 spd_ok_reg, spd_neg_reg, acc_neg_reg;
    logic [63:0]          prod_reg;

    // result register
    logic        m_valid_reg;
    logic [48:0] angle_reg;

    logic                 start_div;
    logic [63:0]          div_num, div_quot;
    logic [31:0]          div_den;
    logic                 div_done;

    logic signed [32:0]   delta;
    logic                 delta_nz;
    logic [TIME_BITS-1:0] dt, since_edge;
    logic signed [32:0]   acc;
    logic [22:0]          mag;
    logic signed [23:0]   rpm_s;
    logic signed [22:0]   rpm_new;
    logic                 outlier;
    logic [22:0]          fq;
    logic signed [22:0]   filt_new;

    // read bookkeeping and edge debounce terms
    always_comb begin
        delta      = $signed({1'b0, count_reg}) - $signed({1'b0, calr_reg});
        delta_nz   = delta != '0;
        dt         = (delta_nz ? latest_ev_reg : now_reg) - tolpr_reg;
        since_edge = now_reg - last_edge_reg;
    end

    // speed magnitude through clamp, deadband and outlier check
    always_comb begin
        logic [63:0] m64;
        m64 = spd_ok_reg ? div_quot : 64'd0;
        mag = (m64 > 64'(LIMIT)) ? LIMIT + 23'd1 : m64[22:0];
        if (mag < HALF) begin
            mag = '0;
        end
        outlier = mag > LIMIT;
        rpm_s   = spd_neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        rpm_new = outlier ? good_reg : rpm_s[22:0];
    end

    // filter numerator and result
    always_comb begin
        logic signed [32:0] w;
        w   = $signed({25'd0, cfg.filter_weight});
        acc = 33'(filt_reg) * w + 33'(good_reg);
        fq  = div_quot[22:0];
        if (({4'd0, fq} * 27'd10) < ONE) begin
            filt_new = '0;
        end else begin
            filt_new = acc_neg_reg ? -$signed(fq) : $signed(fq);
        end
    end

    // divider operand select
    always_comb begin
        unique case (cmd.div_sel)
            DIV_SPEED: begin
                div_num = prod_reg;
                div_den = 32'(dt_reg);
            end
            DIV_FILT: begin
                div_num = 64'(acc[32] ? 33'(-acc) : acc);
                div_den = {23'd0, 9'({1'b0, cfg.filter_weight} + 9'd1)};
            end
            default: begin
                div_num = ANGLE_K[31:0] * count_reg;
                div_den = {16'd0, cfg.pulses_per_rev};
            end
        endcase
    end
    assign start_div = cmd.div_start;

    ese_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_div),
        .num     (div_num),
        .den     (div_den),
        .quot    (div_quot),
        .done    (div_done)
    );

    // item latch and per-read scratch
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= s_func;
            level_reg <= s_pin_level;
            now_reg   <= TIME_BITS'(s_time_us);
        end
        if (cmd.exec) begin
            cnt_reg     <= delta_nz ? (delta[32] ? 32'(-delta) : delta[31:0]) : 32'd1;
            dt_reg      <= dt;
            spd_ok_reg  <= !first_reg && dt != '0;
            spd_neg_reg <= delta[32];
        end
        if (cmd.mul) begin
            prod_reg <= SPEED_K[31:0] * cnt_reg;
        end
        if (cmd.div_start && cmd.div_sel == DIV_FILT) begin
            acc_neg_reg <= acc[32];
        end
    end

    // encoder, speed, filter and peak state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_level_reg <= 1'b1;
            last_edge_reg  <= '0;
            latest_ev_reg  <= '0;
            tolpr_reg      <= '0;
            count_reg      <= '0;
            calr_reg       <= '0;
            first_reg      <= 1'b1;
            good_reg       <= '0;
            filt_reg       <= '0;
            peak_reg       <= '0;
        end else begin
            if (cmd.exec) begin
                unique case (func_reg)
                    FUNC_EDGE: begin
                        latest_ev_reg <= now_reg;
                        if (level_reg != last_level_reg) begin
                            if (since_edge > TIME_BITS'(cfg.debounce_us)) begin
                                last_level_reg <= level_reg;
                                count_reg      <= count_reg + 32'd1;
                            end
                            last_edge_reg <= now_reg;
                        end
                    end
                    FUNC_READ: begin
                        first_reg <= 1'b0;
                        calr_reg  <= count_reg;
                        if (delta_nz) begin
                            tolpr_reg <= latest_ev_reg;
                        end
                    end
                    FUNC_CLEAR: begin
                        count_reg <= '0;
                        peak_reg  <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.rpm) begin
                if (!outlier) begin
                    good_reg <= rpm_s[22:0];
                end
                if (rpm_new > peak_reg) begin
                    peak_reg <= rpm_new;
                end
            end
            if (cmd.fpost) begin
                filt_reg <= filt_new;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            angle_reg      <= (cfg.pulses_per_rev == '0) ? 49'd0 : div_quot[48:0];
            m_pulse_count  <= count_reg;
            m_rpm_raw      <= good_reg;
            m_rpm_filtered <= filt_reg;
            m_rpm_peak     <= peak_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_angle_q8 = angle_reg;

    assign sts.div_done = div_done;
    assign sts.is_read  = func_reg == FUNC_READ;
    assign sts.out_free = !m_valid_reg || m_ready;

    a_good_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rpm |=> good_reg <= $signed(LIMIT) && good_reg >= -$signed(LIMIT))
        else $error("last good speed out of range");
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(m_pulse_count))
        else $error("result lost while stalled");
    a_clear_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && func_reg == FUNC_CLEAR |=> count_reg == '0 && peak_reg == '0)
        else $error("clear did not zero count and peak");

endmodule
`default_nettype wire

[src/ese_ctrl.sv]
// ----------------------------------------------------------------------------
// ese_ctrl: sequencing controller
// Steps one item through execute, speed division and filter division (on
// reads only) and angle division, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module ese_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire ese_pkg::sts_t sts,
    output ese_pkg::cmd_t      cmd
);
    import ese_pkg::*;

    state_t state_reg, state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_valid) state_next = S_EXEC;
            S_EXEC:  state_next = sts.is_read ? S_MUL : S_AGO;
            S_MUL:   state_next = S_SGO;
            S_SGO:   state_next = S_SWAIT;
            S_SWAIT: if (sts.div_done) state_next = S_RPM;
            S_RPM:   state_next = S_FGO;
            S_FGO:   state_next = S_FWAIT;
            S_FWAIT: if (sts.div_done) state_next = S_FPOST;
            S_FPOST: state_next = S_AGO;
            S_AGO:   state_next = S_AWAIT;
            S_AWAIT: if (sts.div_done) state_next = S_DONE;
            S_DONE:  if (sts.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd         = '0;
        cmd.div_sel = DIV_ANGLE;
        s_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_EXEC:  cmd.exec = 1'b1;
            S_MUL:   cmd.mul = 1'b1;
            S_SGO: begin
                cmd.div_sel   = DIV_SPEED;
                cmd.div_start = 1'b1;
            end
            S_SWAIT: cmd.div_sel = DIV_SPEED;
            S_RPM:   cmd.rpm = 1'b1;
            S_FGO: begin
                cmd.div_sel   = DIV_FILT;
                cmd.div_start = 1'b1;
            end
            S_FWAIT: cmd.div_sel = DIV_FILT;
            S_FPOST: cmd.fpost = 1'b1;
            S_AGO:   cmd.div_start = 1'b1;
            S_AWAIT: begin
            end
            S_DONE:  cmd.out_load = sts.out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_EXEC) else $error("accept lost");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free) else $error("result overwritten");
    a_speed_then_rpm: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SWAIT && sts.div_done |=> state_reg == S_RPM)
        else $error("speed division not followed by rpm step");

endmodule
`default_nettype wire

[src/encoder_speed_estimator.sv]
// ----------------------------------------------------------------------------
// encoder_speed_estimator: debounced encoder counter and rpm estimator
// Counts debounced edges of one encoder channel, estimates Q8 rpm with
// deadband, outlier rejection, IIR filter and peak, and reports the angle.
//
//   channel  direction  handshake         payload
//   s_       in         s_valid/s_ready   s_func, s_pin_level, s_time_us
//   m_       out        m_valid/m_ready   m_pulse_count, m_angle_q8, m_rpm_*
//   apb      in         psel/penable      paddr, pwdata, prdata
//
// Edge, clear and no-op items use the bit-serial shared divider once, for
// the angle; speed reads use it once each for speed, filter and angle.
// The next input is taken in the cycle after the result is loaded.
// Reset (aresetn low, synchronous) clears the controller, encoder, speed,
// filter and peak state and m_valid, not the payload; registers return
// to debounce 100, weight 20, pulses per revolution 70.
// A new item is taken while a finished result waits on m_ready.
// ----------------------------------------------------------------------------
`default_nettype none
module encoder_speed_estimator (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_func,
    input  wire logic              s_pin_level,
    input  wire logic [31:0]       s_time_us,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [31:0]            m_pulse_count,
    output logic [48:0]            m_angle_q8,
    output logic signed [22:0]     m_rpm_raw,
    output logic signed [22:0]     m_rpm_filtered,
    output logic signed [22:0]     m_rpm_peak,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import ese_pkg::*;

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;
    logic wr_en;

    // configuration register writes
    assign wr_en = psel && penable && pwrite;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_us    <= 16'd100;
            cfg_reg.filter_weight  <= 8'd20;
            cfg_reg.pulses_per_rev <= 16'd70;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_DEBOUNCE: cfg_reg.debounce_us    <= pwdata[15:0];
                REG_WEIGHT:   cfg_reg.filter_weight  <= pwdata[7:0];
                REG_PPR:      cfg_reg.pulses_per_rev <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[3:2])
            REG_DEBOUNCE: prdata = {16'd0, cfg_reg.debounce_us};
            REG_WEIGHT:   prdata = {24'd0, cfg_reg.filter_weight};
            REG_PPR:      prdata = {16'd0, cfg_reg.pulses_per_rev};
            default:      prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    ese_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ese_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .sts            (sts),
        .s_func         (s_func),
        .s_pin_level    (s_pin_level),
        .s_time_us      (s_time_us),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pulse_count  (m_pulse_count),
        .m_angle_q8     (m_angle_q8),
        .m_rpm_raw      (m_rpm_raw),
        .m_rpm_filtered (m_rpm_filtered),
        .m_rpm_peak     (m_rpm_peak)
    );

endmodule
`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for the encoder speed estimator
// A directed table followed by random pin-change bursts, speed reads and
// clears, with random gaps on both channels and register writes between
// phases. Every result transfer is checked against a local predictor.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    import ese_pkg::*;

    // function code with no effect on state
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic aclk, aresetn;
    logic s_valid, s_ready, s_pin_level;
    logic [1:0] s_func;
    logic [31:0] s_time_us;
    logic m_valid, m_ready;
    logic [31:0] m_pulse_count;
    logic [48:0] m_angle_q8;
    logic signed [22:0] m_rpm_raw, m_rpm_filtered, m_rpm_peak;
    logic psel, penable, pwrite, pready;
    logic [3:0] paddr;
    logic [31:0] pwdata, prdata;

    encoder_speed_estimator dut (.*);

    typedef struct packed {
        logic [31:0] count;
        logic [48:0] angle;
        logic [22:0] raw;
        logic [22:0] filt;
        logic [22:0] peak;
    } speed_result_t;

    typedef struct packed {
        logic [1:0]  func;
        logic        level;
        logic [31:0] t;
        logic        known;
        speed_result_t res;
    } step_row_t;

    // predictor state and registers
    logic [15:0] cfg_debounce;
    logic [7:0]  cfg_weight;
    logic [15:0] cfg_ppr;
    logic        enc_level;
    logic [31:0] edge_time, event_time, edges, edges_at_read, pulse_read_time;
    logic        first_read;
    longint      good_rpm, filt_rpm, peak_rpm;

    speed_result_t expected_q[$];
    int errors = 0;
    longint cycles = 0;
    bit hold_off = 0;
    logic [31:0] clock_us;

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("tb: errors");
            $finish;
        end
    end

    function automatic longint iabs(longint v);
        return v < 0 ? -v : v;
    endfunction

    // models one accepted item and returns the result it produces
    function automatic speed_result_t predict_speed(logic [1:0] f, logic lv, logic [31:0] t);
        speed_result_t r;
        longint delta, rpm;
        logic [31:0] dt;
        logic [127:0] prod;
        longint unsigned mag, cnt;
        rpm = 0;
        if (f == FUNC_EDGE) begin
            event_time = t;
            if (lv != enc_level) begin
                if (32'(t - edge_time) > {16'd0, cfg_debounce}) begin
                    enc_level = lv;
                    edges = edges + 1;
                end
                edge_time = t;
            end
        end else if (f == FUNC_READ) begin
            delta = longint'(edges) - longint'(edges_at_read);
            if (first_read) first_read = 0;
            else begin
                dt = (delta != 0) ? event_time - pulse_read_time : t - pulse_read_time;
                if (dt != 0) begin
                    cnt = (delta != 0) ? iabs(delta) : 1;
                    prod = 128'(SPEED_K) * cnt;
                    if ((prod >> 64) >= dt) mag = 64'hFFFF_FFFF_FFFF_FFFF;
                    else mag = 64'(prod / dt);
                    if (mag > LIMIT) mag = LIMIT + 1;
                    rpm = delta < 0 ? -longint'(mag) : longint'(mag);
                end
            end
            edges_at_read = edges;
            if (delta != 0) pulse_read_time = event_time;
            if (iabs(rpm) < HALF) rpm = 0;
            if (iabs(rpm) > LIMIT) rpm = good_rpm;
            else good_rpm = rpm;
            filt_rpm = (filt_rpm * longint'(cfg_weight) + rpm) / (longint'(cfg_weight) + 1);
            if (iabs(filt_rpm) * 10 < ONE) filt_rpm = 0;
            if (rpm > peak_rpm) peak_rpm = rpm;
        end else if (f == FUNC_CLEAR) begin
            edges = 0;
            peak_rpm = 0;
        end
        r.count = edges;
        r.angle = (cfg_ppr != 0) ? 49'((128'(ANGLE_K) * edges) / cfg_ppr) : '0;
        r.raw = 23'(good_rpm);
        r.filt = 23'(filt_rpm);
        r.peak = 23'(peak_rpm);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // result channel: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 0;
        else m_ready <= !hold_off && ($urandom_range(0, 9) < 7);
    end

    // check every result transfer
    always @(posedge aclk) begin
        speed_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $display("unexpected result transfer at cycle %0d", cycles);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (m_pulse_count !== want.count)
                    report_mismatch("pulse_count", m_pulse_count, want.count);
                if (m_angle_q8 !== want.angle)
                    report_mismatch("angle_q8", m_angle_q8, want.angle);
                if (m_rpm_raw !== want.raw)
                    report_mismatch("rpm_raw", m_rpm_raw, $signed(want.raw));
                if (m_rpm_filtered !== want.filt)
                    report_mismatch("rpm_filtered", m_rpm_filtered, $signed(want.filt));
                if (m_rpm_peak !== want.peak)
                    report_mismatch("rpm_peak", m_rpm_peak, $signed(want.peak));
            end
        end
    end

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) n = 0;
        repeat (n) @(posedge aclk);
    endtask

    // offers one item and waits for its transfer; optionally checks a typed-in result
    task automatic send_item(logic [1:0] f, logic lv, logic [31:0] t, bit known = 0,
                             speed_result_t typed = '0);
        speed_result_t r;
        s_func <= f;
        s_pin_level <= lv;
        s_time_us <= t;
        s_valid <= 1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = predict_speed(f, lv, t);
        if (known && r !== typed) begin
            $display("table row disagrees with predictor, func %0d", f);
            errors++;
        end
        expected_q.push_back(r);
        s_valid <= 0;
        @(posedge aclk);
        idle_gap();
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (expected_q.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_DEBOUNCE: cfg_debounce = val[15:0];
            REG_WEIGHT:   cfg_weight = val[7:0];
            default:      cfg_ppr = val[15:0];
        endcase
        @(posedge aclk);
    endtask

    // a spinning encoder: alternating levels spaced by a period, then a read
    task automatic spin_burst(int unsigned period, int n);
        for (int i = 0; i < n; i++) begin
            clock_us += period + $urandom_range(0, period / 4);
            // occasional bounce just before this edge
            if ($urandom_range(0, 7) == 0)
                send_item(FUNC_EDGE, ~enc_level, clock_us - $urandom_range(0, 40));
            send_item(FUNC_EDGE, ~enc_level, clock_us);
        end
        send_item(FUNC_READ, $urandom_range(0, 1), clock_us + $urandom_range(0, period));
    endtask

    step_row_t table_rows[$];

    function automatic speed_result_t res(logic [31:0] c, logic [48:0] a);
        speed_result_t r;
        r = '0;
        r.count = c;
        r.angle = a;
        return r;
    endfunction

    initial begin
        int sent;
        aresetn = 0;
        s_valid = 0; s_func = FUNC_EDGE; s_pin_level = 1; s_time_us = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        cfg_debounce = 100; cfg_weight = 20; cfg_ppr = 70;
        enc_level = 1; edge_time = 0; event_time = 0; edges = 0;
        edges_at_read = 0; pulse_read_time = 0; first_read = 1;
        good_rpm = 0; filt_rpm = 0; peak_rpm = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed table: typed results only for plain values after reset
        table_rows = '{
            '{FUNC_READ,  1'b0, 32'd0,        1'b1, res(0, 0)},
            '{FUNC_EDGE,  1'b1, 32'd50,       1'b1, res(0, 0)},
            '{FUNC_EDGE,  1'b0, 32'd60,       1'b1, res(0, 0)},
            '{FUNC_EDGE,  1'b0, 32'd200,      1'b1, res(1, 1316)},
            '{FUNC_EDGE,  1'b1, 32'd250,      1'b1, res(1, 1316)},
            '{FUNC_EDGE,  1'b1, 32'd400,      1'b0, res(0, 0)},
            '{FUNC_READ,  1'b1, 32'd400,      1'b0, res(0, 0)},
            '{FUNC_READ,  1'b0, 32'hFFFF_FFFF, 1'b0, res(0, 0)},
            '{FUNC_EDGE,  1'b0, 32'hFFFF_FFF0, 1'b0, res(0, 0)},
            '{FUNC_EDGE,  1'b1, 32'h0000_0100, 1'b0, res(0, 0)},
            '{FUNC_READ,  1'b1, 32'h0000_0200, 1'b0, res(0, 0)},
            '{FUNC_READ,  1'b1, 32'h0000_0200, 1'b0, res(0, 0)},
            '{FUNC_UNUSED, 1'b1, 32'hAAAA_5555, 1'b0, res(0, 0)},
            '{FUNC_EDGE,  1'b0, 32'h0000_0201, 1'b0, res(0, 0)},
            '{FUNC_EDGE,  1'b1, 32'h0000_0202, 1'b0, res(0, 0)},
            '{FUNC_READ,  1'b0, 32'h0000_0203, 1'b0, res(0, 0)},
            '{FUNC_CLEAR, 1'b0, 32'h5555_AAAA, 1'b0, res(0, 0)}
        };
        foreach (table_rows[i])
            send_item(table_rows[i].func, table_rows[i].level, table_rows[i].t,
                      table_rows[i].known, table_rows[i].res);
        drain();

        // extremes of the registers, with fast edges and an outlier
        write_reg(REG_DEBOUNCE, 32'd0);
        write_reg(REG_WEIGHT, 32'd0);
        write_reg(REG_PPR, 32'd1);
        clock_us = 32'hFFFF_FF00;
        spin_burst(1, 6);
        spin_burst(3000, 4);
        send_item(FUNC_READ, 0, clock_us + 32'h8000_0000);
        drain();
        write_reg(REG_DEBOUNCE, 32'hFFFF);
        write_reg(REG_WEIGHT, 32'hFF);
        write_reg(REG_PPR, 32'hFFFF);
        spin_burst(70000, 3);
        send_item(FUNC_CLEAR, 0, 0);
        drain();

        // random phases with varied settings
        write_reg(REG_DEBOUNCE, 32'd100);
        write_reg(REG_WEIGHT, 32'd20);
        write_reg(REG_PPR, 32'd70);
        sent = 0;
        for (int phase = 0; phase < 5; phase++) begin
            if (phase == 2) begin
                // long receiver hold-off while the sender keeps offering
                fork
                    begin
                        hold_off = 1;
                        repeat (3000) @(posedge aclk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int k = 0; k < 140; k++) begin
                case ($urandom_range(0, 9))
                    0: send_item($urandom_range(0, 3), $urandom_range(0, 1), $urandom());
                    1: send_item(FUNC_CLEAR, $urandom_range(0, 1), $urandom());
                    2, 3: send_item(FUNC_READ, $urandom_range(0, 1),
                                    clock_us + $urandom_range(0, 100000));
                    default: begin
                        clock_us += $urandom_range(0, 400);
                        send_item(FUNC_EDGE, $urandom_range(0, 4) != 0 ? ~enc_level
                                  : enc_level, clock_us);
                    end
                endcase
                if ($urandom_range(0, 15) == 0) begin
                    spin_burst($urandom_range(150, 20000), $urandom_range(1, 8));
                    k += 3;
                end
            end
            drain();
            write_reg(REG_DEBOUNCE, $urandom_range(0, 300));
            write_reg(REG_WEIGHT, $urandom_range(0, 255));
            write_reg(REG_PPR, $urandom_range(0, 65535));
        end
        drain();

        if (errors == 0 && expected_q.size() == 0) begin
            $display("tb: clean");
        end else begin
            if (expected_q.size() != 0)
                $display("%0d expected results never arrived", expected_q.size());
            $display("tb: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
